// ===== rtl/core/asss_pkg.sv =====
package asss_pkg;

    localparam int VAL_W   = 24;
    localparam int SCL_W   = 14;
    localparam int DIG_W   = 4;
    localparam int POS_N   = 4;
    localparam int POS_W   = 2;
    localparam int SEG_W   = 7;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [2:0] {
        RNG_P0   = 3'd0,
        RNG_P1   = 3'd1,
        RNG_P2   = 3'd2,
        RNG_NONE = 3'd3,
        RNG_ERR  = 3'd4
    } t_range;

    localparam logic [VAL_W-1:0] LIM_P0  = 24'd10000;
    localparam logic [VAL_W-1:0] LIM_P1  = 24'd100000;
    localparam logic [VAL_W-1:0] LIM_P2  = 24'd1000000;
    localparam logic [VAL_W-1:0] LIM_ERR = 24'd10000000;

    // floor(v / d) = (v * ceil(2^34 / d)) >> 34 for any 24-bit v
    localparam int WIDE_SH  = 34;
    localparam int REC1_W   = 31;
    localparam int PROD1_W  = VAL_W + REC1_W;
    localparam logic [REC1_W-1:0] REC34_10   = 31'd1717986919;
    localparam logic [REC1_W-1:0] REC34_100  = 31'd171798692;
    localparam logic [REC1_W-1:0] REC34_1000 = 31'd17179870;

    // floor(s / d) = (s * ceil(2^24 / d)) >> 24 for any 14-bit s
    localparam int SMALL_SH = 24;
    localparam int REC2_W   = 21;
    localparam int PROD2_W  = SCL_W + REC2_W;
    localparam logic [REC2_W-1:0] REC24_10   = 21'd1677722;
    localparam logic [REC2_W-1:0] REC24_100  = 21'd167773;
    localparam logic [REC2_W-1:0] REC24_1000 = 21'd16778;

    localparam int Q1000_W = 4;
    localparam int Q100_W  = 7;
    localparam int Q10_W   = 10;

    localparam logic [DIG_W-1:0] DIGIT_ERR = 4'd10;
    localparam logic [SEG_W-1:0] SEG_ERR   = 7'h79;

    localparam logic [POS_N-1:0][DIG_W-1:0] DIGIT_RESET = {4'd3, 4'd2, 4'd1, 4'd0};

    typedef struct packed {
        logic load;
        logic tick;
    } t_store_cmd;

    function automatic logic [SEG_W-1:0] seg_of(input logic [DIG_W-1:0] d);
        logic [SEG_W-1:0] s;
        unique case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = SEG_ERR;
        endcase
        return s;
    endfunction

    function automatic logic [SCL_W-1:0] times_ten(input logic [SCL_W-1:0] x);
        return SCL_W'({x, 3'b000}) + SCL_W'({x, 1'b0});
    endfunction

endpackage

// ===== rtl/core/asss_store.sv =====
module asss_store
    import asss_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_store_cmd                  i_cmd,
    input  logic [POS_N-1:0][DIG_W-1:0] i_digits,
    input  logic [POS_N-1:0]            i_points,
    output logic [SEG_W-1:0]            o_segments,
    output logic                        o_decimal_point,
    output logic [POS_N-1:0]            o_digit_select_n
);

    logic [POS_N-1:0][DIG_W-1:0] r_digits;
    logic [POS_N-1:0]            r_points;
    logic [POS_W-1:0]            r_pos;
    logic [POS_W-1:0]            n_pos;

    assign n_pos = r_pos + POS_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digits <= DIGIT_RESET;
            r_points <= '0;
            r_pos    <= '0;
        end else begin
            if (i_cmd.load) begin
                r_digits <= i_digits;
                r_points <= i_points;
            end
            if (i_cmd.tick) begin
                r_pos <= n_pos;
            end
        end
    end

    assign o_segments       = seg_of(r_digits[n_pos]);
    assign o_decimal_point  = r_points[n_pos];
    assign o_digit_select_n = ~(POS_N'(1) << n_pos);

endmodule

// ===== rtl/core/autorange_seven_segment_scanner.sv =====
// channel | direction | handshake                 | payload
// in      | input     | i_in_valid / o_in_ready   | i_req_type, i_value_thousandths
// out     | output    | o_out_valid / i_out_ready | o_segments, o_decimal_point,
//         |           |                           | o_digit_select_n
//
// One transfer in per cycle while o_in_ready is high; a scan tick reaches the output register.
// Three stages (range and wide reciprocal multiply, digit reciprocal multiplies, digit
// assembly and store update) feed the output register; loads leave no output.
// Reset is synchronous; the display store comes up as 0,1,2,3 with no points.
// A stalled output holds its item; stages fill up behind it before o_in_ready drops.
module autorange_seven_segment_scanner
    import asss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_req_type,
    input  logic [VAL_W-1:0]  i_value_thousandths,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [SEG_W-1:0]  o_segments,
    output logic              o_decimal_point,
    output logic [POS_N-1:0]  o_digit_select_n
);

    logic               r_s1_valid;
    logic               r_s1_req;
    logic [VAL_W-1:0]   r_s1_value;

    logic               r_s2_valid;
    logic               r_s2_req;
    t_range             r_s2_range;
    logic [SCL_W-1:0]   r_s2_scaled;

    logic               r_s3_valid;
    logic               r_s3_req;
    t_range             r_s3_range;
    logic [SCL_W-1:0]   r_s3_scaled;
    logic [Q1000_W-1:0] r_s3_q1000;
    logic [Q100_W-1:0]  r_s3_q100;
    logic [Q10_W-1:0]   r_s3_q10;

    logic               r_out_valid;
    logic [SEG_W-1:0]   r_segments;
    logic               r_decimal_point;
    logic [POS_N-1:0]   r_digit_select_n;

    logic out_free;
    logic s3_go;
    logic s3_rdy;
    logic s2_rdy;
    logic s1_rdy;

    t_range              n_range;
    logic [REC1_W-1:0]   rec_wide;
    logic [PROD1_W-1:0]  prod_wide;
    logic [SCL_W-1:0]    n_scaled;

    logic [PROD2_W-1:0]  prod_1000;
    logic [PROD2_W-1:0]  prod_100;
    logic [PROD2_W-1:0]  prod_10;

    logic [SCL_W-1:0]    diff1;
    logic [SCL_W-1:0]    diff2;
    logic [SCL_W-1:0]    diff3;
    logic [POS_N-1:0][DIG_W-1:0] n_digits;
    logic [POS_N-1:0]    n_points;

    t_store_cmd          store_cmd;
    logic [SEG_W-1:0]    st_segments;
    logic                st_decimal_point;
    logic [POS_N-1:0]    st_digit_select_n;

    assign out_free   = !r_out_valid || i_out_ready;
    assign s3_go      = r_s3_valid && (r_s3_req == REQ_LOAD || out_free);
    assign s3_rdy     = !r_s3_valid || s3_go;
    assign s2_rdy     = !r_s2_valid || s3_rdy;
    assign s1_rdy     = !r_s1_valid || s2_rdy;
    assign o_in_ready = s1_rdy;

    always_comb begin
        if (r_s1_value >= LIM_ERR) begin
            n_range = RNG_ERR;
        end else if (r_s1_value < LIM_P0) begin
            n_range = RNG_P0;
        end else if (r_s1_value < LIM_P1) begin
            n_range = RNG_P1;
        end else if (r_s1_value < LIM_P2) begin
            n_range = RNG_P2;
        end else begin
            n_range = RNG_NONE;
        end
    end

    always_comb begin
        unique case (n_range)
            RNG_P1:   rec_wide = REC34_10;
            RNG_P2:   rec_wide = REC34_100;
            RNG_NONE: rec_wide = REC34_1000;
            default:  rec_wide = '0;
        endcase
    end

    assign prod_wide = PROD1_W'(r_s1_value) * PROD1_W'(rec_wide);
    assign n_scaled  = (n_range == RNG_P0) ? r_s1_value[SCL_W-1:0]
                                           : prod_wide[WIDE_SH +: SCL_W];

    assign prod_1000 = PROD2_W'(r_s2_scaled) * PROD2_W'(REC24_1000);
    assign prod_100  = PROD2_W'(r_s2_scaled) * PROD2_W'(REC24_100);
    assign prod_10   = PROD2_W'(r_s2_scaled) * PROD2_W'(REC24_10);

    assign diff1 = SCL_W'(r_s3_q100) - times_ten(SCL_W'(r_s3_q1000));
    assign diff2 = SCL_W'(r_s3_q10) - times_ten(SCL_W'(r_s3_q100));
    assign diff3 = r_s3_scaled - times_ten(SCL_W'(r_s3_q10));

    always_comb begin
        n_digits[0] = r_s3_q1000;
        n_digits[1] = diff1[DIG_W-1:0];
        n_digits[2] = diff2[DIG_W-1:0];
        n_digits[3] = diff3[DIG_W-1:0];
        n_points    = '0;
        unique case (r_s3_range)
            RNG_P0:   n_points[0] = 1'b1;
            RNG_P1:   n_points[1] = 1'b1;
            RNG_P2:   n_points[2] = 1'b1;
            RNG_NONE: n_points    = '0;
            RNG_ERR: begin
                n_digits = {POS_N{DIGIT_ERR}};
            end
            default:  n_points    = '0;
        endcase
    end

    assign store_cmd.load = s3_go && (r_s3_req == REQ_LOAD);
    assign store_cmd.tick = s3_go && (r_s3_req == REQ_TICK);

    asss_store u_store (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (store_cmd),
        .i_digits         (n_digits),
        .i_points         (n_points),
        .o_segments       (st_segments),
        .o_decimal_point  (st_decimal_point),
        .o_digit_select_n (st_digit_select_n)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_rdy) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_rdy) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s3_rdy) begin
                r_s3_valid <= r_s2_valid;
            end
            if (store_cmd.tick) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && s1_rdy) begin
            r_s1_req   <= i_req_type;
            r_s1_value <= i_value_thousandths;
        end
        if (r_s1_valid && s2_rdy) begin
            r_s2_req    <= r_s1_req;
            r_s2_range  <= n_range;
            r_s2_scaled <= n_scaled;
        end
        if (r_s2_valid && s3_rdy) begin
            r_s3_req    <= r_s2_req;
            r_s3_range  <= r_s2_range;
            r_s3_scaled <= r_s2_scaled;
            r_s3_q1000  <= prod_1000[SMALL_SH +: Q1000_W];
            r_s3_q100   <= prod_100[SMALL_SH +: Q100_W];
            r_s3_q10    <= prod_10[SMALL_SH +: Q10_W];
        end
        if (store_cmd.tick) begin
            r_segments       <= st_segments;
            r_decimal_point  <= st_decimal_point;
            r_digit_select_n <= st_digit_select_n;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_segments       = r_segments;
    assign o_decimal_point  = r_decimal_point;
    assign o_digit_select_n = r_digit_select_n;

endmodule

// ===== rtl/core/asss_checker.sv =====
module asss_checker
    import asss_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [SEG_W-1:0]  o_segments,
    input logic              o_decimal_point,
    input logic [POS_N-1:0]  o_digit_select_n
);

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_segments)
            && $stable(o_decimal_point) && $stable(o_digit_select_n))
        else $error("stalled output transfer changed");

    a_one_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $countones(~o_digit_select_n) == 1)
        else $error("digit select not one-hot low");

    a_no_last_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_decimal_point |-> o_digit_select_n != 4'b0111)
        else $error("point lit on last position");

    a_error_no_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_segments == SEG_ERR |-> !o_decimal_point)
        else $error("point lit on error digit");

endmodule

bind autorange_seven_segment_scanner asss_checker u_asss_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_segments       (o_segments),
    .o_decimal_point  (o_decimal_point),
    .o_digit_select_n (o_digit_select_n)
);

// ===== tb/tb_autorange_seven_segment_scanner.sv =====
`timescale 1ns / 100ps

module tb_autorange_seven_segment_scanner;
    import asss_pkg::*;

    localparam int RAND_ITEMS  = 1000;
    localparam int DRAIN_EVERY = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYC  = 10;
    localparam int PLAN_N      = 25;

    typedef struct packed {
        logic [SEG_W-1:0] seg;
        logic             dp;
        logic [POS_N-1:0] sel_n;
    } scan_frame_t;

    typedef struct {
        logic             req;
        logic [VAL_W-1:0] value;
        bit               typed;
        scan_frame_t      want;
    } plan_row_t;

    localparam scan_frame_t NO_FRAME = '{7'h00, 1'b0, 4'hF};

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    logic             i_req_type;
    logic [VAL_W-1:0] i_value_thousandths;
    logic             o_out_valid;
    logic             i_out_ready;
    logic [SEG_W-1:0] o_segments;
    logic             o_decimal_point;
    logic [POS_N-1:0] o_digit_select_n;

    logic [DIG_W-1:0] shadow_digit [POS_N];
    logic             shadow_point [POS_N];
    logic [POS_W-1:0] shadow_pos;

    scan_frame_t frames_due [$];

    int  errors;
    int  n_loads;
    int  n_bad_loads;
    int  n_ticks;
    int  n_frames;
    int  idle_cycles;
    int  rx_hold;
    bit  tx_calm;
    bit  rx_calm;

    plan_row_t plan [PLAN_N] = '{
        '{REQ_TICK, 24'd0,        1'b1, '{7'h06,   1'b0, 4'b1101}},
        '{REQ_TICK, 24'hFFFFFF,   1'b1, '{7'h5B,   1'b0, 4'b1011}},
        '{REQ_TICK, 24'd0,        1'b1, '{7'h4F,   1'b0, 4'b0111}},
        '{REQ_TICK, 24'd0,        1'b1, '{7'h3F,   1'b0, 4'b1110}},
        '{REQ_LOAD, 24'd10000000, 1'b0, NO_FRAME},
        '{REQ_TICK, 24'd0,        1'b1, '{SEG_ERR, 1'b0, 4'b1101}},
        '{REQ_TICK, 24'd0,        1'b1, '{SEG_ERR, 1'b0, 4'b1011}},
        '{REQ_LOAD, 24'hFFFFFF,   1'b0, NO_FRAME},
        '{REQ_TICK, 24'd0,        1'b1, '{SEG_ERR, 1'b0, 4'b0111}},
        '{REQ_LOAD, 24'd0,        1'b0, NO_FRAME},
        '{REQ_TICK, 24'd0,        1'b0, NO_FRAME},
        '{REQ_LOAD, 24'd9999,     1'b0, NO_FRAME},
        '{REQ_TICK, 24'd0,        1'b0, NO_FRAME},
        '{REQ_LOAD, 24'd10000,    1'b0, NO_FRAME},
        '{REQ_TICK, 24'd0,        1'b0, NO_FRAME},
        '{REQ_LOAD, 24'd99999,    1'b0, NO_FRAME},
        '{REQ_TICK, 24'd0,        1'b0, NO_FRAME},
        '{REQ_LOAD, 24'd100000,   1'b0, NO_FRAME},
        '{REQ_TICK, 24'd0,        1'b0, NO_FRAME},
        '{REQ_LOAD, 24'd999999,   1'b0, NO_FRAME},
        '{REQ_TICK, 24'd0,        1'b0, NO_FRAME},
        '{REQ_LOAD, 24'd1000000,  1'b0, NO_FRAME},
        '{REQ_TICK, 24'd0,        1'b0, NO_FRAME},
        '{REQ_LOAD, 24'd9999999,  1'b0, NO_FRAME},
        '{REQ_TICK, 24'd0,        1'b0, NO_FRAME}
    };

    autorange_seven_segment_scanner uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_req_type          (i_req_type),
        .i_value_thousandths (i_value_thousandths),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_segments          (o_segments),
        .o_decimal_point     (o_decimal_point),
        .o_digit_select_n    (o_digit_select_n)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [SEG_W-1:0] glyph_of(input logic [DIG_W-1:0] d);
        logic [SEG_W-1:0] g;
        case (d)
            4'd0:    g = 7'h3F;
            4'd1:    g = 7'h06;
            4'd2:    g = 7'h5B;
            4'd3:    g = 7'h4F;
            4'd4:    g = 7'h66;
            4'd5:    g = 7'h6D;
            4'd6:    g = 7'h7D;
            4'd7:    g = 7'h07;
            4'd8:    g = 7'h7F;
            4'd9:    g = 7'h6F;
            default: g = SEG_ERR;
        endcase
        return g;
    endfunction

    task automatic store_reading(input logic [VAL_W-1:0] v);
        t_range      rng;
        int unsigned shown;
        rng = (v < LIM_P0) ? RNG_P0 :
              (v < LIM_P1) ? RNG_P1 :
              (v < LIM_P2) ? RNG_P2 :
              (v < LIM_ERR) ? RNG_NONE : RNG_ERR;
        for (int k = 0; k < POS_N; k++) shadow_point[k] = 1'b0;
        case (rng)
            RNG_P0:   shown = v;
            RNG_P1:   shown = v / 10;
            RNG_P2:   shown = v / 100;
            default:  shown = v / 1000;
        endcase
        if (rng == RNG_ERR) begin
            for (int k = 0; k < POS_N; k++) shadow_digit[k] = DIGIT_ERR;
        end else begin
            shadow_digit[0] = DIG_W'((shown / 1000) % 10);
            shadow_digit[1] = DIG_W'((shown / 100) % 10);
            shadow_digit[2] = DIG_W'((shown / 10) % 10);
            shadow_digit[3] = DIG_W'(shown % 10);
            case (rng)
                RNG_P0:  shadow_point[0] = 1'b1;
                RNG_P1:  shadow_point[1] = 1'b1;
                RNG_P2:  shadow_point[2] = 1'b1;
                default: ;
            endcase
        end
    endtask

    function automatic scan_frame_t advance_scan();
        scan_frame_t f;
        shadow_pos = shadow_pos + 1'b1;
        f.seg   = glyph_of(shadow_digit[shadow_pos]);
        f.dp    = shadow_point[shadow_pos];
        f.sel_n = ~(POS_N'(1) << shadow_pos);
        return f;
    endfunction

    function automatic logic [VAL_W-1:0] pick_reading();
        logic [VAL_W-1:0] v;
        case ($urandom_range(0, 6))
            0: v = $urandom_range(0, 9999);
            1: v = $urandom_range(10000, 99999);
            2: v = $urandom_range(100000, 999999);
            3: v = $urandom_range(1000000, 9999999);
            4: v = $urandom_range(10000000, 16777215);
            5: v = VAL_W'($urandom);
            default: begin
                case ($urandom_range(0, 9))
                    0: v = 24'd0;
                    1: v = 24'd9999;
                    2: v = 24'd10000;
                    3: v = 24'd99999;
                    4: v = 24'd100000;
                    5: v = 24'd999999;
                    6: v = 24'd1000000;
                    7: v = 24'd9999999;
                    8: v = 24'd10000000;
                    default: v = 24'hFFFFFF;
                endcase
            end
        endcase
        return v;
    endfunction

    // enter and leave at a falling edge
    task automatic send_request(input logic req, input logic [VAL_W-1:0] v,
                                input bit typed, input scan_frame_t want);
        int          gap;
        scan_frame_t f;
        gap = tx_calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_req_type          <= req;
        i_value_thousandths <= v;
        do @(posedge i_clk); while (!o_in_ready);
        if (req == REQ_LOAD) begin
            store_reading(v);
            n_loads++;
            if (v >= LIM_ERR) n_bad_loads++;
        end else begin
            f = advance_scan();
            frames_due.push_back(typed ? want : f);
            n_ticks++;
        end
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (frames_due.size() == 0) begin
                $error("unexpected display frame: segments %h", o_segments);
                errors++;
            end else begin
                scan_frame_t exp_f;
                exp_f = frames_due.pop_front();
                n_frames++;
                if (o_segments !== exp_f.seg) begin
                    $error("segments: expected %h, actual %h", exp_f.seg, o_segments);
                    errors++;
                end
                if (o_decimal_point !== exp_f.dp) begin
                    $error("decimal_point: expected %b, actual %b", exp_f.dp,
                           o_decimal_point);
                    errors++;
                end
                if (o_digit_select_n !== exp_f.sel_n) begin
                    $error("digit_select_n: expected %b, actual %b", exp_f.sel_n,
                           o_digit_select_n);
                    errors++;
                end
            end
            rx_hold <= rx_calm ? 0 : $urandom_range(0, 7);
        end
    end

    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            i_out_ready <= 1'b0;
            rx_hold     <= rx_hold - 1;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT) begin
                    $display("RESULT: ERROR");
                    $finish;
                end
            end
        end
    end

    initial begin
        int sent;
        int next_drain;
        int burst;
        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        i_in_valid          = 1'b0;
        i_req_type          = REQ_LOAD;
        i_value_thousandths = '0;
        i_out_ready         = 1'b0;
        rx_hold             = 0;
        errors              = 0;
        idle_cycles         = 0;
        tx_calm             = 1'b0;
        rx_calm             = 1'b0;
        for (int k = 0; k < POS_N; k++) begin
            shadow_digit[k] = DIGIT_RESET[k];
            shadow_point[k] = 1'b0;
        end
        shadow_pos = '0;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < PLAN_N; r++)
            send_request(plan[r].req, plan[r].value, plan[r].typed, plan[r].want);

        sent       = 0;
        next_drain = DRAIN_EVERY;
        while (sent < RAND_ITEMS) begin
            if ($urandom_range(0, 19) == 0) tx_calm = !tx_calm;
            if ($urandom_range(0, 19) == 0) rx_calm = !rx_calm;
            if (sent >= next_drain) begin
                // hold off until the display pipeline is empty
                i_in_valid <= 1'b0;
                do @(negedge i_clk); while (frames_due.size() != 0);
                next_drain += DRAIN_EVERY;
            end
            if ($urandom_range(0, 9) < 7) begin
                send_request(REQ_LOAD, pick_reading(), 1'b0, NO_FRAME);
                sent++;
                burst = $urandom_range(1, 8);
                repeat (burst) begin
                    send_request(REQ_TICK, VAL_W'($urandom), 1'b0, NO_FRAME);
                    sent++;
                end
            end else begin
                if ($urandom_range(0, 1) == 0)
                    send_request(REQ_LOAD, pick_reading(), 1'b0, NO_FRAME);
                else
                    send_request(REQ_TICK, VAL_W'($urandom), 1'b0, NO_FRAME);
                sent++;
            end
        end

        i_in_valid <= 1'b0;
        while (frames_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
        errors += frames_due.size();

        $display("Covered %0d value loads (%0d out of range) and %0d scan ticks,",
                 n_loads, n_bad_loads, n_ticks);
        $display("with %0d display frames compared against the shadow display.", n_frames);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/asss_pkg.sv
rtl/core/asss_store.sv
rtl/core/autorange_seven_segment_scanner.sv
rtl/core/asss_checker.sv
tb/tb_autorange_seven_segment_scanner.sv
